// ----- sv/upstream_load_balance_picker_top_macros.svh -----
// ----------------------------------------------------------------------------
// upstream_load_balance_picker_top_macros.svh
// Assertion helpers for the checker file; clock clk, reset arst_n.
// ----------------------------------------------------------------------------
`ifndef UPSTREAM_LOAD_BALANCE_PICKER_TOP_MACROS_SVH
`define UPSTREAM_LOAD_BALANCE_PICKER_TOP_MACROS_SVH

// same-cycle implication
`define ULBP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ulbp assertion failed");

// next-cycle implication
`define ULBP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ulbp assertion failed");

`endif

// ----- sv/ulbp_pkg.sv -----
// ----------------------------------------------------------------------------
// ulbp_pkg
// Types, register and mode codes and helpers for the upstream picker.
// ----------------------------------------------------------------------------
package ulbp_pkg;

	localparam int MAX_UPSTREAMS_DEF = 8;
	localparam int WEIGHT_BITS_DEF   = 8;
	localparam int INFLIGHT_BITS_DEF = 16;

	localparam int LANE_LIMIT = 8;
	localparam int HASH_W     = 64;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int UIDX_W     = 3;
	localparam int MASK_W     = 8;
	localparam int CAP_W      = 16;
	localparam int CW_W       = 16;
	localparam int MODE_W     = 3;
	localparam int COUNT_W    = 4;
	localparam int WSLOT_W    = 8;
	localparam int MOD_BITS   = 8;
	localparam int MOD_CYCLES = HASH_W / MOD_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_PICK_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPSTREAM_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INFLIGHT_CAP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TABLE   = 3'd3;

	localparam logic [MODE_W-1:0] MODE_RR     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LEAST  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HASH   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_WRR    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_COOKIE = 3'd4;

	localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd8;
	localparam logic [CFG_W-1:0]    WEIGHT_RESET = 64'h0101_0101_0101_0101;

	typedef enum logic [1:0] {ALG_RR, ALG_LEAST, ALG_HASH, ALG_WRR} alg_t;

	typedef enum logic [2:0] {ST_IDLE, ST_MOD, ST_SCAN, ST_FIX, ST_UPD, ST_REL} state_t;

	typedef struct packed {
		logic if_we;
		logic cw_we;
	} lane_wr_t;

	// one restoring remainder step; r < n <= 8
	function automatic logic [3:0] mod_step(logic [3:0] r, logic b, logic [3:0] n);
		logic [3:0] s;
		s = {r[2:0], b};
		return (s >= n) ? (s - n) : s;
	endfunction

	function automatic logic signed [CW_W-1:0] sat16(logic signed [CW_W:0] v);
		if (v > 17'sd32767)
			return 16'sh7fff;
		else if (v < -17'sd32768)
			return 16'sh8000;
		else
			return v[CW_W-1:0];
	endfunction

endpackage

// ----- sv/ulbp_mod_unit.sv -----
// ----------------------------------------------------------------------------
// ulbp_mod_unit
// Reduces a 64-bit hash modulo the upstream count, eight bits per cycle.
// ----------------------------------------------------------------------------
module ulbp_mod_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ulbp_pkg::HASH_W-1:0]   hash,
	input  logic [ulbp_pkg::COUNT_W-1:0]  n,
	output logic                          done,
	output logic [ulbp_pkg::UIDX_W-1:0]   rem
);
	localparam int CNT_W = $clog2(ulbp_pkg::MOD_CYCLES);

	logic                        active_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [ulbp_pkg::HASH_W-1:0] sh_q;
	logic [3:0]                  rem_q;
	logic [3:0]                  rem_d;

	always_comb begin
		rem_d = rem_q;
		for (int k = 0; k < ulbp_pkg::MOD_BITS; k++) begin
			rem_d = ulbp_pkg::mod_step(rem_d, sh_q[ulbp_pkg::HASH_W-1-k], n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ulbp_pkg::MOD_CYCLES - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= hash;
			rem_q <= '0;
		end else if (active_q) begin
			sh_q  <= sh_q << ulbp_pkg::MOD_BITS;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[ulbp_pkg::UIDX_W-1:0];

endmodule

// ----- sv/ulbp_lane_file.sv -----
// ----------------------------------------------------------------------------
// ulbp_lane_file
// Per-upstream in-flight counts and smooth-WRR current weights.
// ----------------------------------------------------------------------------
module ulbp_lane_file #(
	parameter int NUM_LANES     = ulbp_pkg::LANE_LIMIT,
	parameter int INFLIGHT_BITS = ulbp_pkg::INFLIGHT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(NUM_LANES)-1:0]        idx,
	input  ulbp_pkg::lane_wr_t                  wr,
	input  logic [INFLIGHT_BITS-1:0]            if_wdata,
	input  logic signed [ulbp_pkg::CW_W-1:0]    cw_wdata,
	output logic [INFLIGHT_BITS-1:0]            if_rdata,
	output logic signed [ulbp_pkg::CW_W-1:0]    cw_rdata
);
	logic [INFLIGHT_BITS-1:0]         if_q [NUM_LANES];
	logic signed [ulbp_pkg::CW_W-1:0] cw_q [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				if_q[i] <= '0;
				cw_q[i] <= '0;
			end
		end else begin
			if (wr.if_we)
				if_q[idx] <= if_wdata;
			if (wr.cw_we)
				cw_q[idx] <= cw_wdata;
		end
	end

	assign if_rdata = if_q[idx];
	assign cw_rdata = cw_q[idx];

endmodule

// ----- sv/upstream_load_balance_picker_top.sv -----
// ----------------------------------------------------------------------------
// upstream_load_balance_picker_top
// Grants one upstream per pick request; tracks in-flight counts.
// ----------------------------------------------------------------------------
// Command channel: a transfer happens when start is high and busy is low.
// cmd 0 picks an upstream from eligible_mask in the mode set by pick_mode;
// cmd 1 releases one in-flight slot of release_index.
// Every command gives one result: done pulses for one cycle with granted
// and upstream_index. The receiver cannot stall; the result is gone after
// that cycle.
// n = active upstreams. Hash modes first reduce the 64-bit hash modulo n
// (8 bits per cycle) before the lane scan.
// One lane is visited per cycle through a single read/modify port on the
// lane file. busy stays high for the whole command, but a pick answered at
// once (count 0 or an unused mode) never raises it; the next command can be
// taken in the done cycle.
// Config writes (cfg_we) take effect at once and are meant for idle time.
// Reset clears in-flight counts, current weights, the cursor and loads the
// register defaults; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module upstream_load_balance_picker_top #(
	parameter int MAX_UPSTREAMS = ulbp_pkg::MAX_UPSTREAMS_DEF,
	parameter int WEIGHT_BITS   = ulbp_pkg::WEIGHT_BITS_DEF,
	parameter int INFLIGHT_BITS = ulbp_pkg::INFLIGHT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            cmd,
	input  logic [ulbp_pkg::MASK_W-1:0]     eligible_mask,
	input  logic [ulbp_pkg::HASH_W-1:0]     client_hash,
	input  logic                            hash_present,
	input  logic [ulbp_pkg::UIDX_W-1:0]     release_index,
	output logic                            done,
	output logic                            granted,
	output logic [ulbp_pkg::UIDX_W-1:0]     upstream_index,
	input  logic                            cfg_we,
	input  logic [ulbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ulbp_pkg::CFG_W-1:0]      cfg_wdata
);
	localparam int NUM_LANES = (MAX_UPSTREAMS < ulbp_pkg::LANE_LIMIT) ?
		MAX_UPSTREAMS : ulbp_pkg::LANE_LIMIT;
	localparam int LIDX_W = $clog2(NUM_LANES);
	localparam int CMP_W  = (INFLIGHT_BITS > ulbp_pkg::CAP_W) ? INFLIGHT_BITS : ulbp_pkg::CAP_W;
	localparam int TOT_W  = WEIGHT_BITS + 3;
	localparam int CW_W   = ulbp_pkg::CW_W;
	localparam logic [ulbp_pkg::COUNT_W-1:0] NUM_LANES_N = ulbp_pkg::COUNT_W'(NUM_LANES);
	localparam logic [INFLIGHT_BITS-1:0] IF_MAX = '1;

	// configuration
	logic [ulbp_pkg::MODE_W-1:0]  mode_q;
	logic [ulbp_pkg::COUNT_W-1:0] count_q;
	logic [ulbp_pkg::CAP_W-1:0]   cap_q;
	logic [ulbp_pkg::CFG_W-1:0]   weight_q;

	ulbp_pkg::state_t state_q, state_d;
	ulbp_pkg::alg_t   alg_q, alg_d;

	logic [ulbp_pkg::COUNT_W-1:0] n_q, n_cfg;
	logic [ulbp_pkg::MASK_W-1:0]  mask_q;
	logic [LIDX_W-1:0]            c_q, t_q, best_q, rel_q, cursor_q, c_nxt, start_c, lane_idx;
	logic                         rel_ok_q, found_q;
	logic [INFLIGHT_BITS-1:0]     best_if_q;
	logic signed [CW_W-1:0]       best_cw_q;
	logic [TOT_W-1:0]             total_q;
	logic                         done_q, granted_q;
	logic [ulbp_pkg::UIDX_W-1:0]  uidx_q;

	logic                         accept, go_pick, mode_ok;
	logic                         fin, fin_grant, mod_start, mod_done;
	logic [ulbp_pkg::UIDX_W-1:0]  mod_rem;
	ulbp_pkg::lane_wr_t           lane_wr;
	logic [INFLIGHT_BITS-1:0]     if_rd, if_wdata;
	logic signed [CW_W-1:0]       cw_rd, cw_wdata, cw_sum, cw_fix;
	logic [WEIGHT_BITS-1:0]       w_c;
	logic                         usable, last_try, better_least, better_wrr;
	logic [3:0]                   c_inc, cr;

	assign accept = start && (state_q == ulbp_pkg::ST_IDLE);
	assign n_cfg  = (count_q > NUM_LANES_N) ? NUM_LANES_N : count_q;

	// start candidate for round robin: cursor mod n
	always_comb begin
		cr = '0;
		for (int k = LIDX_W - 1; k >= 0; k--) begin
			cr = ulbp_pkg::mod_step(cr, cursor_q[k], n_cfg);
		end
		start_c = cr[LIDX_W-1:0];
	end

	always_comb begin
		mode_ok = 1'b1;
		alg_d   = ulbp_pkg::ALG_RR;
		case (mode_q)
			ulbp_pkg::MODE_RR:     alg_d = ulbp_pkg::ALG_RR;
			ulbp_pkg::MODE_LEAST:  alg_d = ulbp_pkg::ALG_LEAST;
			ulbp_pkg::MODE_HASH:   alg_d = ulbp_pkg::ALG_HASH;
			ulbp_pkg::MODE_WRR:    alg_d = ulbp_pkg::ALG_WRR;
			ulbp_pkg::MODE_COOKIE: alg_d = hash_present ? ulbp_pkg::ALG_HASH : ulbp_pkg::ALG_RR;
			default:               mode_ok = 1'b0;
		endcase
	end
	assign go_pick = !cmd && (n_cfg != '0) && mode_ok;

	// lane datapath
	always_comb begin
		case (state_q)
			ulbp_pkg::ST_REL:  lane_idx = rel_q;
			ulbp_pkg::ST_SCAN: lane_idx = c_q;
			default:           lane_idx = best_q;
		endcase
	end

	assign c_inc    = ulbp_pkg::COUNT_W'(c_q) + 4'd1;
	assign c_nxt    = (c_inc == n_q) ? '0 : c_inc[LIDX_W-1:0];
	assign last_try = ((ulbp_pkg::COUNT_W'(t_q) + 4'd1) == n_q);
	assign usable   = mask_q[c_q] &&
		((cap_q == '0) || (CMP_W'(if_rd) < CMP_W'(cap_q)));
	assign w_c      = weight_q[ulbp_pkg::WSLOT_W*c_q +: WEIGHT_BITS];
	assign cw_sum   = ulbp_pkg::sat16($signed({cw_rd[CW_W-1], cw_rd}) +
		$signed({{(CW_W+1-WEIGHT_BITS){1'b0}}, w_c}));
	assign cw_fix   = ulbp_pkg::sat16($signed({best_cw_q[CW_W-1], best_cw_q}) -
		$signed({{(CW_W+1-TOT_W){1'b0}}, total_q}));
	assign better_least = !found_q || (if_rd < best_if_q);
	assign better_wrr   = !found_q || (cw_sum > best_cw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ulbp_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		fin       = 1'b0;
		fin_grant = 1'b0;
		mod_start = 1'b0;
		lane_wr   = '0;
		if_wdata  = if_rd;
		cw_wdata  = cw_sum;
		case (state_q)
			ulbp_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd)
						state_d = ulbp_pkg::ST_REL;
					else if (!go_pick)
						fin = 1'b1;
					else if (alg_d == ulbp_pkg::ALG_HASH) begin
						state_d   = ulbp_pkg::ST_MOD;
						mod_start = 1'b1;
					end else
						state_d = ulbp_pkg::ST_SCAN;
				end
			end
			ulbp_pkg::ST_MOD: begin
				if (mod_done)
					state_d = ulbp_pkg::ST_SCAN;
			end
			ulbp_pkg::ST_SCAN: begin
				case (alg_q)
					ulbp_pkg::ALG_LEAST: begin
						if (last_try) begin
							if (found_q || usable)
								state_d = ulbp_pkg::ST_UPD;
							else begin
								state_d = ulbp_pkg::ST_IDLE;
								fin     = 1'b1;
							end
						end
					end
					ulbp_pkg::ALG_WRR: begin
						lane_wr.cw_we = usable;
						if (last_try) begin
							if (found_q || usable)
								state_d = ulbp_pkg::ST_FIX;
							else begin
								state_d = ulbp_pkg::ST_IDLE;
								fin     = 1'b1;
							end
						end
					end
					default: begin
						if (usable)
							state_d = ulbp_pkg::ST_UPD;
						else if (last_try) begin
							state_d = ulbp_pkg::ST_IDLE;
							fin     = 1'b1;
						end
					end
				endcase
			end
			ulbp_pkg::ST_FIX: begin
				lane_wr.cw_we = 1'b1;
				cw_wdata      = cw_fix;
				state_d       = ulbp_pkg::ST_UPD;
			end
			ulbp_pkg::ST_UPD: begin
				lane_wr.if_we = (if_rd != IF_MAX);
				if_wdata      = if_rd + 1'b1;
				fin           = 1'b1;
				fin_grant     = 1'b1;
				state_d       = ulbp_pkg::ST_IDLE;
			end
			ulbp_pkg::ST_REL: begin
				lane_wr.if_we = rel_ok_q && (if_rd != '0);
				if_wdata      = if_rd - 1'b1;
				fin           = 1'b1;
				state_d       = ulbp_pkg::ST_IDLE;
			end
			default: state_d = ulbp_pkg::ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ulbp_pkg::MODE_RR;
			count_q  <= ulbp_pkg::COUNT_RESET;
			cap_q    <= '0;
			weight_q <= ulbp_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ulbp_pkg::REG_PICK_MODE:      mode_q   <= cfg_wdata[ulbp_pkg::MODE_W-1:0];
				ulbp_pkg::REG_UPSTREAM_COUNT: count_q  <= cfg_wdata[ulbp_pkg::COUNT_W-1:0];
				ulbp_pkg::REG_INFLIGHT_CAP:   cap_q    <= cfg_wdata[ulbp_pkg::CAP_W-1:0];
				ulbp_pkg::REG_WEIGHT_TABLE:   weight_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
			granted_q <= 1'b0;
			uidx_q    <= '0;
		end else begin
			done_q    <= fin;
			granted_q <= fin_grant;
			uidx_q    <= fin_grant ? ulbp_pkg::UIDX_W'(best_q) : '0;
			if (accept)
				found_q <= 1'b0;
			else if (state_q == ulbp_pkg::ST_SCAN) begin
				case (alg_q)
					ulbp_pkg::ALG_RR:    cursor_q <= c_nxt;
					ulbp_pkg::ALG_LEAST: if (usable) found_q <= 1'b1;
					ulbp_pkg::ALG_WRR:   if (usable) found_q <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	// per-command working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			alg_q    <= alg_d;
			n_q      <= n_cfg;
			mask_q   <= eligible_mask;
			rel_q    <= release_index[LIDX_W-1:0];
			rel_ok_q <= (int'(release_index) < NUM_LANES);
			c_q      <= (alg_d == ulbp_pkg::ALG_RR) ? start_c : '0;
			t_q      <= '0;
			total_q  <= '0;
		end else if (state_q == ulbp_pkg::ST_MOD) begin
			c_q <= mod_rem[LIDX_W-1:0];
		end else if (state_q == ulbp_pkg::ST_SCAN) begin
			c_q <= c_nxt;
			t_q <= t_q + 1'b1;
			case (alg_q)
				ulbp_pkg::ALG_LEAST: begin
					if (usable && better_least) begin
						best_q    <= c_q;
						best_if_q <= if_rd;
					end
				end
				ulbp_pkg::ALG_WRR: begin
					if (usable) begin
						total_q <= total_q + TOT_W'(w_c);
						if (better_wrr) begin
							best_q    <= c_q;
							best_cw_q <= cw_sum;
						end
					end
				end
				default: begin
					if (usable)
						best_q <= c_q;
				end
			endcase
		end
	end

	ulbp_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.hash   (client_hash),
		.n      (n_q),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	ulbp_lane_file #(
		.NUM_LANES     (NUM_LANES),
		.INFLIGHT_BITS (INFLIGHT_BITS)
	) u_lanes (
		.clk      (clk),
		.arst_n   (arst_n),
		.idx      (lane_idx),
		.wr       (lane_wr),
		.if_wdata (if_wdata),
		.cw_wdata (cw_wdata),
		.if_rdata (if_rd),
		.cw_rdata (cw_rd)
	);

	assign busy           = (state_q != ulbp_pkg::ST_IDLE);
	assign done           = done_q;
	assign granted        = granted_q;
	assign upstream_index = uidx_q;

endmodule

// ----- sv/ulbp_checker.sv -----
// ----------------------------------------------------------------------------
// ulbp_checker
// Port-level checks on the picker's command and result behavior.
// ----------------------------------------------------------------------------
`include "upstream_load_balance_picker_top_macros.svh"

module ulbp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic                           granted,
	input logic [ulbp_pkg::UIDX_W-1:0]    upstream_index
);
	// the result cycle is always an idle cycle
	`ULBP_ASSERT_IMP(a_done_idle, done, !busy)
	// an accepted command either keeps the block busy or answers at once
	`ULBP_ASSERT_NXT(a_accept_resp, start && !busy, busy || done)
	// no grant reports index zero
	`ULBP_ASSERT_IMP(a_idx_zero, done && !granted, upstream_index == '0)
	// grant is only shown with the strobe
	`ULBP_ASSERT_IMP(a_grant_strobe, !done, !granted)

endmodule

bind upstream_load_balance_picker_top ulbp_checker u_ulbp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.granted        (granted),
	.upstream_index (upstream_index)
);

// ----- bench/upstream_load_balance_picker_top_test.sv -----
// ----------------------------------------------------------------------------
// upstream_load_balance_picker_top_test
// Self-checking bench: drives pick/release commands and register writes,
// predicts each grant in-line and compares every done strobe in order.
// ----------------------------------------------------------------------------
module upstream_load_balance_picker_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ulbp_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [ulbp_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
	localparam logic [ulbp_pkg::CFG_IDX_W-1:0] REG_UNKNOWN_LO = 3'd4;
	localparam logic [ulbp_pkg::CFG_IDX_W-1:0] REG_UNKNOWN_HI = 3'd7;
	localparam bit CMD_PICK = 1'b0;
	localparam bit CMD_RELEASE = 1'b1;
	localparam logic [15:0] INFLIGHT_SAT = 16'hffff;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic granted;
		logic [ulbp_pkg::UIDX_W-1:0] idx;
	} grant_t;

	logic clk, arst_n, start, busy, cmd, hash_present, done, granted, cfg_we;
	logic [ulbp_pkg::MASK_W-1:0] eligible_mask;
	logic [ulbp_pkg::HASH_W-1:0] client_hash;
	logic [ulbp_pkg::UIDX_W-1:0] release_index, upstream_index;
	logic [ulbp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ulbp_pkg::CFG_W-1:0] cfg_wdata;

	upstream_load_balance_picker_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.eligible_mask(eligible_mask), .client_hash(client_hash),
		.hash_present(hash_present), .release_index(release_index),
		.done(done), .granted(granted), .upstream_index(upstream_index),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [2:0] mode_r;
	logic [3:0] count_r;
	logic [15:0] cap_r;
	logic [63:0] weights_r;
	int unsigned cursor;
	logic [15:0] inflight [8];
	int cur_weight [8];

	grant_t grants_due[$];
	int mismatches;
	int unsigned cycles;
	bit quiet;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		grant_t exp_g;
		if (arst_n && done) begin
			if (grants_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: granted=%0d idx=%0d", granted, upstream_index);
			end else begin
				exp_g = grants_due.pop_front();
				if (granted !== exp_g.granted || upstream_index !== exp_g.idx) begin
					mismatches++;
					if (mismatches <= 10)
						$display("grant mismatch: exp %0d/%0d got %0d/%0d", exp_g.granted,
							exp_g.idx, granted, upstream_index);
				end
			end
		end
	end

	function automatic bit usable(int i, logic [7:0] m);
		if (!m[i])
			return 0;
		if (cap_r != 0 && inflight[i] >= cap_r)
			return 0;
		return 1;
	endfunction

	function automatic int rr_choose(int n, logic [7:0] m);
		int i;
		for (int t = 0; t < n; t++) begin
			i = cursor % n;
			cursor = (i + 1) % n;
			if (usable(i, m))
				return i;
		end
		return -1;
	endfunction

	function automatic int hash_choose(int n, logic [7:0] m, logic [63:0] h);
		int s, i;
		s = int'(h % 64'(n));
		for (int t = 0; t < n; t++) begin
			i = (s + t) % n;
			if (usable(i, m))
				return i;
		end
		return -1;
	endfunction

	function automatic int sat16(int v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic int wrr_choose(int n, logic [7:0] m);
		int best, total, w;
		best = -1;
		total = 0;
		for (int i = 0; i < n; i++) begin
			if (!usable(i, m))
				continue;
			w = int'(weights_r[8*i +: 8]);
			cur_weight[i] = sat16(cur_weight[i] + w);
			total += w;
			if (best < 0 || cur_weight[i] > cur_weight[best])
				best = i;
		end
		if (best >= 0)
			cur_weight[best] = sat16(cur_weight[best] - total);
		return best;
	endfunction

	function automatic grant_t predict_grant(bit c, logic [7:0] m, logic [63:0] h, bit hp,
			logic [2:0] rel);
		grant_t g;
		int n, pick;
		g = '0;
		pick = -1;
		n = count_r > 8 ? 8 : int'(count_r);
		if (c == CMD_RELEASE) begin
			if (inflight[rel] > 0)
				inflight[rel] -= 1;
			return g;
		end
		if (n == 0)
			return g;
		case (mode_r)
			ulbp_pkg::MODE_RR:     pick = rr_choose(n, m);
			ulbp_pkg::MODE_LEAST: begin
				for (int i = 0; i < n; i++)
					if (usable(i, m) && (pick < 0 || inflight[i] < inflight[pick]))
						pick = i;
			end
			ulbp_pkg::MODE_HASH:   pick = hash_choose(n, m, h);
			ulbp_pkg::MODE_WRR:    pick = wrr_choose(n, m);
			ulbp_pkg::MODE_COOKIE: pick = hp ? hash_choose(n, m, h) : rr_choose(n, m);
			default:               pick = -1;
		endcase
		if (pick >= 0) begin
			if (inflight[pick] < INFLIGHT_SAT)
				inflight[pick] += 1;
			g.granted = 1;
			g.idx = pick[2:0];
		end
		return g;
	endfunction

	// random gap before a command, unless in a no-idle stretch
	task automatic maybe_gap();
		if (!quiet && $urandom_range(99) < 8) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_cmd(bit c, logic [7:0] m, logic [63:0] h, bit hp, logic [2:0] rel);
		maybe_gap();
		cmd <= c;
		eligible_mask <= m;
		client_hash <= h;
		hash_present <= hp;
		release_index <= rel;
		start <= 1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		grants_due.push_back(predict_grant(c, m, h, hp, rel));
	endtask

	task automatic pick_req(logic [7:0] m, logic [63:0] h, bit hp);
		send_cmd(CMD_PICK, m, h, hp, 3'($urandom));
	endtask

	task automatic release_req(logic [2:0] rel);
		send_cmd(CMD_RELEASE, 8'($urandom), {$urandom, $urandom}, 1'($urandom), rel);
	endtask

	// stop sending and wait for every expected result
	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			ulbp_pkg::REG_PICK_MODE:      mode_r = val[2:0];
			ulbp_pkg::REG_UPSTREAM_COUNT: count_r = val[3:0];
			ulbp_pkg::REG_INFLIGHT_CAP:   cap_r = val[15:0];
			ulbp_pkg::REG_WEIGHT_TABLE:   weights_r = val;
			default: ;
		endcase
	endtask

	task automatic release_all();
		for (int i = 0; i < 8; i++)
			while (inflight[i] != 0)
				release_req(3'(i));
	endtask

	task automatic test_modes();
		// reset defaults: round robin over eight, weights all one
		for (int i = 0; i < 10; i++)
			pick_req(8'hff, 64'd0, 0);
		pick_req(8'h00, 64'd0, 0);
		write_reg(ulbp_pkg::REG_PICK_MODE, ulbp_pkg::MODE_HASH);
		pick_req(8'hff, 64'hffff_ffff_ffff_ffff, 0);
		pick_req(8'h81, 64'd0, 0);
		write_reg(ulbp_pkg::REG_PICK_MODE, ulbp_pkg::MODE_COOKIE);
		pick_req(8'h5a, 64'h8000_0000_0000_0001, 1);
		pick_req(8'h5a, 64'h8000_0000_0000_0001, 0);
		write_reg(ulbp_pkg::REG_PICK_MODE, ulbp_pkg::MODE_LEAST);
		pick_req(8'hff, 64'd0, 0);
		pick_req(8'h0c, 64'd0, 0);
		write_reg(ulbp_pkg::REG_PICK_MODE, ulbp_pkg::MODE_WRR);
		write_reg(ulbp_pkg::REG_WEIGHT_TABLE, 64'hff00_0102_0304_05ff);
		for (int i = 0; i < 4; i++)
			pick_req(8'hff, 64'd0, 0);
		write_reg(ulbp_pkg::REG_PICK_MODE, MODE_UNUSED_LO);
		pick_req(8'hff, 64'd0, 0);
		write_reg(ulbp_pkg::REG_PICK_MODE, MODE_UNUSED_HI);
		pick_req(8'hff, 64'd0, 0);
		release_req(3'd7);
		release_req(3'd7);
	endtask

	task automatic test_counts_and_cap();
		write_reg(ulbp_pkg::REG_PICK_MODE, ulbp_pkg::MODE_RR);
		write_reg(ulbp_pkg::REG_UPSTREAM_COUNT, 4'd0);
		pick_req(8'hff, 64'd0, 0);
		release_req(3'd0);
		write_reg(ulbp_pkg::REG_UPSTREAM_COUNT, 4'd15);
		pick_req(8'hff, 64'd0, 0);
		write_reg(REG_UNKNOWN_LO, 64'hffff_ffff_ffff_ffff);
		write_reg(REG_UNKNOWN_HI, 64'd0);
		write_reg(ulbp_pkg::REG_UPSTREAM_COUNT, 4'd3);
		write_reg(ulbp_pkg::REG_INFLIGHT_CAP, 16'd1);
		release_all();
		for (int i = 0; i < 5; i++)
			pick_req(8'hff, 64'd0, 0);
		release_all();
	endtask

	// in-flight count builds up on one upstream; a cap of all ones lets it through
	task automatic test_saturation();
		write_reg(ulbp_pkg::REG_INFLIGHT_CAP, 16'd0);
		write_reg(ulbp_pkg::REG_UPSTREAM_COUNT, 4'd1);
		write_reg(ulbp_pkg::REG_PICK_MODE, ulbp_pkg::MODE_LEAST);
		quiet = 1;
		for (int i = 0; i < 40; i++)
			pick_req(8'h01, 64'd0, 0);
		quiet = 0;
		write_reg(ulbp_pkg::REG_INFLIGHT_CAP, 16'hffff);
		pick_req(8'h01, 64'd0, 0);
		release_req(3'd0);
		pick_req(8'h01, 64'd0, 0);
		write_reg(ulbp_pkg::REG_INFLIGHT_CAP, 16'd0);
		release_all();
	endtask

	task automatic test_random();
		logic [63:0] w;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(ulbp_pkg::REG_PICK_MODE, $urandom_range(99) < 90 ?
				3'($urandom_range(4)) :
				3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)));
			write_reg(ulbp_pkg::REG_UPSTREAM_COUNT, ph == 0 ? 4'd8 : (ph == 1 ? 4'd15 :
				($urandom_range(9) == 0 ? 4'($urandom) : 4'($urandom_range(1, 8)))));
			write_reg(ulbp_pkg::REG_INFLIGHT_CAP, ph == 2 ? 16'hffff :
				($urandom_range(3) == 0 ? 16'd0 : 16'($urandom_range(1, 6))));
			w = {$urandom, $urandom};
			if (ph == 3)
				w = 64'hffff_ffff_ffff_ffff;
			else if (ph == 4)
				w = 64'd0;
			write_reg(ulbp_pkg::REG_WEIGHT_TABLE, w);
			quiet = (ph == 5);
			for (int i = 0; i < 250; i++) begin
				if ($urandom_range(99) < 35)
					release_req(3'($urandom));
				else
					pick_req($urandom_range(3) == 0 ? 8'hff : 8'($urandom),
						{$urandom, $urandom}, 1'($urandom));
			end
			quiet = 0;
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		cmd = 0;
		eligible_mask = '0;
		client_hash = '0;
		hash_present = 0;
		release_index = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		mode_r = ulbp_pkg::MODE_RR;
		count_r = ulbp_pkg::COUNT_RESET;
		cap_r = '0;
		weights_r = ulbp_pkg::WEIGHT_RESET;
		cursor = 0;
		mismatches = 0;
		cycles = 0;
		quiet = 0;
		for (int i = 0; i < 8; i++) begin
			inflight[i] = '0;
			cur_weight[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_modes();
		test_counts_and_cap();
		test_saturation();
		test_random();
		drain();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
